// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, held off while reset is high.
`define COSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication into the next cycle, held off while reset is high.
`define COSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication into the next cycle, checked through reset as well.
`define COSC_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cosc_pkg.sv -----
`timescale 1ns / 1ps

package cosc_pkg;

  localparam int CLIP_DEPTH_DEF   = 16;
  localparam int ORIGIN_DEPTH_DEF = 16;

  localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd80;
  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd25;
  localparam logic [7:0]  TAB_SPACING_RST   = 8'd8;
  localparam logic [7:0]  TAB_OFFSET_RST    = 8'd0;

  // remainder unit: 16 bit magnitude, 4 bits retired per cycle
  localparam int DIV_BITS   = 16;
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = DIV_BITS / DIV_STEP;

  typedef enum logic [3:0] {
    OP_PUSH_CLIP   = 4'd0,
    OP_POP_CLIP    = 4'd1,
    OP_CLEAR_CLIP  = 4'd2,
    OP_PUSH_ORIGIN = 4'd3,
    OP_POP_ORIGIN  = 4'd4,
    OP_CLEAR_ORIGIN = 4'd5,
    OP_MOVE_TO     = 4'd6,
    OP_WRITE_SPAN  = 4'd7,
    OP_TAB         = 4'd8,
    OP_NEWLINE     = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_CLIP_UNDER   = 3'd1,
    ST_ORIGIN_UNDER = 3'd2,
    ST_CLIP_FULL    = 3'd3,
    ST_ORIGIN_FULL  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_TAB,
    S_CALC
  } state_t;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_TAB_SPACING   = 2'd2,
    REG_TAB_OFFSET    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        start;
    logic [15:0] magnitude;
    logic [7:0]  spacing;
  } tab_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] remainder;
  } tab_rsp_t;

  typedef struct packed {
    logic signed [15:0] start;
    logic [11:0]        len;
  } span_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7FFF;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // overlap of [s, s+n) with [s2, s2+n2): larger start, length or zero
  function automatic span_t overlap(input logic signed [15:0] s, input logic [11:0] n,
                                    input logic signed [15:0] s2, input logic [11:0] n2);
    logic signed [17:0] a;
    logic signed [17:0] e1;
    logic signed [17:0] e2;
    logic signed [17:0] e;
    span_t r;
    a  = (s > s2) ? 18'(s) : 18'(s2);
    e1 = 18'(s) + $signed({6'd0, n});
    e2 = 18'(s2) + $signed({6'd0, n2});
    e  = (e1 < e2) ? e1 : e2;
    r.start = a[15:0];
    r.len   = (e > a) ? 12'(e - a) : 12'd0;
    return r;
  endfunction

endpackage

// ----- hdl/cosc_ram.sv -----
`timescale 1ns / 1ps

module cosc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/cosc_tab_div.sv -----
`timescale 1ns / 1ps

// Remainder of a 16 bit magnitude by the tab spacing, restoring form,
// DIV_STEP bits a cycle. Spacing zero counts as one.
module cosc_tab_div (
  input  logic               clk,
  input  logic               rst,
  input  cosc_pkg::tab_req_t req,
  output cosc_pkg::tab_rsp_t rsp
);

  localparam int CNT_W = (cosc_pkg::DIV_CYCLES > 1) ? $clog2(cosc_pkg::DIV_CYCLES) : 1;

  logic                               busy;
  logic                               done;
  logic [CNT_W-1:0]                   cnt;
  logic [7:0]                         rem;
  logic [7:0]                         dsr;
  logic [cosc_pkg::DIV_BITS-1:0]      dvd;
  logic [7:0]                         rem_step;
  logic [cosc_pkg::DIV_BITS-1:0]      dvd_step;

  always_comb begin
    logic [8:0] r9;
    rem_step = rem;
    dvd_step = dvd;
    for (int i = 0; i < cosc_pkg::DIV_STEP; i++) begin
      r9       = {rem_step, dvd_step[cosc_pkg::DIV_BITS-1]};
      dvd_step = {dvd_step[cosc_pkg::DIV_BITS-2:0], 1'b0};
      rem_step = (r9 >= {1'b0, dsr}) ? 8'(r9 - {1'b0, dsr}) : r9[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(cosc_pkg::DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.magnitude;
      dsr <= (req.spacing == 8'd0) ? 8'd1 : req.spacing;
    end else if (busy) begin
      rem <= rem_step;
      dvd <= dvd_step;
    end
  end

  assign rsp = '{done: done, remainder: rem};

endmodule

// ----- hdl/clip_origin_stack_cursor_engine_unit.sv -----
`timescale 1ns / 1ps

// Clip and origin stack cursor engine for a character-cell terminal. Commands
// arrive as single beats on the s_ side (operation in s_tuser); every command
// returns exactly one beat on the m_ side (status in m_tuser) carrying the
// skip and write counts of a span and the cursor after the command. One
// command is in flight at a time: an ordinary command passes through accept,
// stack read and compute, and its result is registered in the compute cycle;
// a tab waits between stack read and compute in the remainder unit, which
// retires 4 bits of |column - offset| a cycle and then flags completion. The
// clip and origin stacks live in two RAMs with a registered read; the entry
// on top is read as the command is accepted, and pushes write back in the
// compute cycle. A result that waits on m_tready holds the next command in
// its compute cycle; no clearing pass runs after reset. Configuration is on
// the APB port: screen width at 0x0, screen height at 0x4, tab spacing at
// 0x8, tab offset at 0xC.
module clip_origin_stack_cursor_engine_unit #(
  parameter int CLIP_DEPTH   = cosc_pkg::CLIP_DEPTH_DEF,
  parameter int ORIGIN_DEPTH = cosc_pkg::ORIGIN_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // row_value, column_value, extent_height, extent_width
  input  logic [3:0]  s_tuser,  // operation
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // skip_count, write_count, cursor_row_out, cursor_column_out
  output logic [2:0]  m_tuser,  // status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CAW = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
  localparam int CCW = $clog2(CLIP_DEPTH + 1);
  localparam int OAW = (ORIGIN_DEPTH > 1) ? $clog2(ORIGIN_DEPTH) : 1;
  localparam int OCW = $clog2(ORIGIN_DEPTH + 1);

  // ---------------------------------------------------------------- config
  logic [11:0] screen_width;
  logic [11:0] screen_height;
  logic [7:0]  tab_spacing;
  logic [7:0]  tab_offset;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= cosc_pkg::SCREEN_WIDTH_RST;
      screen_height <= cosc_pkg::SCREEN_HEIGHT_RST;
      tab_spacing   <= cosc_pkg::TAB_SPACING_RST;
      tab_offset    <= cosc_pkg::TAB_OFFSET_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (cosc_pkg::reg_idx_t'(paddr[3:2]))
        cosc_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[11:0];
        cosc_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[11:0];
        cosc_pkg::REG_TAB_SPACING:   tab_spacing   <= pwdata[7:0];
        cosc_pkg::REG_TAB_OFFSET:    tab_offset    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cosc_pkg::reg_idx_t'(paddr[3:2]))
      cosc_pkg::REG_SCREEN_WIDTH:  prdata = {20'd0, screen_width};
      cosc_pkg::REG_SCREEN_HEIGHT: prdata = {20'd0, screen_height};
      cosc_pkg::REG_TAB_SPACING:   prdata = {24'd0, tab_spacing};
      cosc_pkg::REG_TAB_OFFSET:    prdata = {24'd0, tab_offset};
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  cosc_pkg::state_t state, state_next;
  cosc_pkg::tab_req_t tab_req;
  cosc_pkg::tab_rsp_t tab_rsp;
  logic calc_fire;

  // command held for the whole operation
  cosc_pkg::op_t      op;
  logic signed [15:0] row_value;
  logic signed [15:0] column_value;
  logic [11:0]        extent_height;
  logic [11:0]        extent_width;

  // architectural state outside the RAMs
  logic [CCW-1:0]     clip_cnt;
  logic [OCW-1:0]     org_cnt;
  logic signed [15:0] cur_row;
  logic signed [15:0] cur_col;

  assign calc_fire = (state == cosc_pkg::S_CALC) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      cosc_pkg::S_IDLE: if (s_tvalid) state_next = cosc_pkg::S_PREP;
      cosc_pkg::S_PREP: state_next = (op == cosc_pkg::OP_TAB) ? cosc_pkg::S_TAB
                                                               : cosc_pkg::S_CALC;
      cosc_pkg::S_TAB:  if (tab_rsp.done) state_next = cosc_pkg::S_CALC;
      cosc_pkg::S_CALC: if (calc_fire) state_next = cosc_pkg::S_IDLE;
      default:          state_next = cosc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == cosc_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cosc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op            <= cosc_pkg::op_t'(s_tuser);
      row_value     <= s_tdata[15:0];
      column_value  <= s_tdata[31:16];
      extent_height <= s_tdata[43:32];
      extent_width  <= s_tdata[55:44];
    end
  end

  // ---------------------------------------------------------------- stacks
  // Read the top entry every cycle; the address follows the depth, which
  // only moves in the compute cycle, so the data is settled by the prep cycle.
  logic [CCW-1:0] clip_cnt_m1;
  logic [OCW-1:0] org_cnt_m1;
  logic [55:0]    clip_rd;
  logic [31:0]    org_rd;
  logic           clip_we;
  logic [55:0]    clip_wdata;
  logic           org_we;
  logic [31:0]    org_wdata;

  assign clip_cnt_m1 = clip_cnt - 1'b1;
  assign org_cnt_m1  = org_cnt - 1'b1;

  cosc_ram #(.WIDTH(56), .DEPTH(CLIP_DEPTH)) u_clip_ram (
    .clk   (clk),
    .we    (clip_we),
    .waddr (clip_cnt[CAW-1:0]),
    .wdata (clip_wdata),
    .raddr (clip_cnt_m1[CAW-1:0]),
    .rdata (clip_rd)
  );

  cosc_ram #(.WIDTH(32), .DEPTH(ORIGIN_DEPTH)) u_origin_ram (
    .clk   (clk),
    .we    (org_we),
    .waddr (org_cnt[OAW-1:0]),
    .wdata (org_wdata),
    .raddr (org_cnt_m1[OAW-1:0]),
    .rdata (org_rd)
  );

  // ---------------------------------------------------------------- prep
  // Empty origin stack means (0,0); empty clip stack means no extra clip.
  logic               have_clip;
  logic signed [15:0] top_row;
  logic signed [15:0] top_col;
  logic [11:0]        top_h;
  logic [11:0]        top_w;
  logic signed [15:0] o_row;
  logic signed [15:0] o_col;
  logic signed [16:0] tab_c;
  logic [16:0]        tab_mag;
  cosc_pkg::span_t    mask_r;
  cosc_pkg::span_t    mask_c;

  assign have_clip = (clip_cnt != '0);
  assign top_row   = clip_rd[15:0];
  assign top_col   = clip_rd[31:16];
  assign top_h     = clip_rd[43:32];
  assign top_w     = clip_rd[55:44];
  assign o_row     = (org_cnt != '0) ? $signed(org_rd[15:0]) : 16'sd0;
  assign o_col     = (org_cnt != '0) ? $signed(org_rd[31:16]) : 16'sd0;

  always_comb begin
    // screen rectangle clipped by the top of the stack
    if (have_clip) begin
      mask_r = cosc_pkg::overlap(16'sd0, screen_height, top_row, top_h);
      mask_c = cosc_pkg::overlap(16'sd0, screen_width, top_col, top_w);
    end else begin
      mask_r = '{start: 16'sd0, len: screen_height};
      mask_c = '{start: 16'sd0, len: screen_width};
    end
    tab_c   = 17'(cur_col) - $signed({9'd0, tab_offset});
    tab_mag = tab_c[16] ? 17'(-tab_c) : 17'(tab_c);
  end

  // start the remainder unit from the prep cycle of a tab
  assign tab_req = '{start:     (state == cosc_pkg::S_PREP) && (op == cosc_pkg::OP_TAB),
                     magnitude: tab_mag[15:0],
                     spacing:   tab_spacing};

  // held from the prep cycle into the compute cycle
  logic signed [15:0] pos_row;
  logic signed [15:0] pos_col;
  logic               have_clip_q;
  logic signed [15:0] tc_row;
  logic signed [15:0] tc_col;
  logic [11:0]        tc_h;
  logic [11:0]        tc_w;
  cosc_pkg::span_t    m_row;
  cosc_pkg::span_t    m_col;
  logic signed [15:0] o_col_q;
  logic               tab_neg;

  always_ff @(posedge clk) begin
    if (state == cosc_pkg::S_PREP) begin
      pos_row     <= cosc_pkg::sat16(18'(row_value) + 18'(o_row));
      pos_col     <= cosc_pkg::sat16(18'(column_value) + 18'(o_col));
      have_clip_q <= have_clip;
      tc_row      <= top_row;
      tc_col      <= top_col;
      tc_h        <= top_h;
      tc_w        <= top_w;
      m_row       <= mask_r;
      m_col       <= mask_c;
      o_col_q     <= o_col;
      tab_neg     <= tab_c[16];
    end
  end

  cosc_tab_div u_tab_div (
    .clk (clk),
    .rst (rst),
    .req (tab_req),
    .rsp (tab_rsp)
  );

  // ---------------------------------------------------------------- compute
  logic signed [15:0] cur_row_next;
  logic signed [15:0] cur_col_next;
  logic [CCW-1:0]     clip_cnt_next;
  logic [OCW-1:0]     org_cnt_next;
  cosc_pkg::status_t  status_next;
  logic [11:0]        skip_next;
  logic [11:0]        write_next;

  always_comb begin
    cosc_pkg::span_t    ir;
    cosc_pkg::span_t    ic;
    logic signed [17:0] ew;
    logic signed [17:0] left;
    logic signed [17:0] last;
    logic signed [17:0] edge_col;
    logic signed [17:0] right;
    logic signed [17:0] sp;
    logic signed [17:0] rem;
    logic signed [17:0] tab_t;
    logic               in_rows;
    logic               hit;

    ew       = $signed({6'd0, extent_width});
    sp       = $signed({10'd0, (tab_spacing == 8'd0) ? 8'd1 : tab_spacing});
    rem      = $signed({10'd0, tab_rsp.remainder});
    in_rows  = (cur_row >= m_row.start) &&
               (18'(cur_row) < 18'(m_row.start) + $signed({6'd0, m_row.len}));
    left     = (cur_col < m_col.start) ? 18'(m_col.start) - 18'(cur_col) : 18'sd0;
    last     = 18'(cur_col) + ew;
    edge_col = 18'(m_col.start) + $signed({6'd0, m_col.len});
    right    = (last > edge_col) ? last - edge_col : 18'sd0;
    hit      = (extent_width != 12'd0) && in_rows && (left < ew) && (right < ew - left);

    // tab stop from the remainder of |column - offset|
    if (!tab_neg) tab_t = 18'(cur_col) - rem + sp;
    else if (rem == 18'sd0) tab_t = 18'(cur_col) + sp;
    else tab_t = 18'(cur_col) + rem;

    if (have_clip_q) begin
      ir = cosc_pkg::overlap(pos_row, extent_height, tc_row, tc_h);
      ic = cosc_pkg::overlap(pos_col, extent_width, tc_col, tc_w);
    end else begin
      ir = '{start: pos_row, len: extent_height};
      ic = '{start: pos_col, len: extent_width};
    end

    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    clip_cnt_next = clip_cnt;
    org_cnt_next  = org_cnt;
    status_next   = cosc_pkg::ST_OK;
    skip_next     = 12'd0;
    write_next    = 12'd0;
    clip_we       = 1'b0;
    org_we        = 1'b0;
    clip_wdata    = {ic.len, ir.len, ic.start, ir.start};
    org_wdata     = {pos_col, pos_row};

    case (op)
      cosc_pkg::OP_PUSH_CLIP: begin
        if (clip_cnt == CCW'(CLIP_DEPTH)) begin
          status_next = cosc_pkg::ST_CLIP_FULL;
        end else begin
          clip_we       = calc_fire;
          clip_cnt_next = clip_cnt + 1'b1;
        end
      end
      cosc_pkg::OP_POP_CLIP: begin
        if (clip_cnt == '0) status_next = cosc_pkg::ST_CLIP_UNDER;
        else clip_cnt_next = clip_cnt_m1;
      end
      cosc_pkg::OP_CLEAR_CLIP: clip_cnt_next = '0;
      cosc_pkg::OP_PUSH_ORIGIN: begin
        if (org_cnt == OCW'(ORIGIN_DEPTH)) begin
          status_next = cosc_pkg::ST_ORIGIN_FULL;
        end else begin
          org_we       = calc_fire;
          org_cnt_next = org_cnt + 1'b1;
        end
      end
      cosc_pkg::OP_POP_ORIGIN: begin
        if (org_cnt == '0) status_next = cosc_pkg::ST_ORIGIN_UNDER;
        else org_cnt_next = org_cnt_m1;
      end
      cosc_pkg::OP_CLEAR_ORIGIN: org_cnt_next = '0;
      cosc_pkg::OP_MOVE_TO: begin
        cur_row_next = pos_row;
        cur_col_next = pos_col;
      end
      cosc_pkg::OP_WRITE_SPAN: begin
        if (extent_width != 12'd0) begin
          cur_col_next = cosc_pkg::sat16(18'(cur_col) + ew);
          if (hit) begin
            skip_next  = left[11:0];
            write_next = 12'(ew - left - right);
          end
        end
      end
      cosc_pkg::OP_TAB: cur_col_next = cosc_pkg::sat16(tab_t);
      cosc_pkg::OP_NEWLINE: begin
        cur_row_next = cosc_pkg::sat16(18'(cur_row) + 18'sd1);
        cur_col_next = o_col_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_cnt <= '0;
      org_cnt  <= '0;
      cur_row  <= 16'sd0;
      cur_col  <= 16'sd0;
      m_tvalid <= 1'b0;
    end else begin
      if (calc_fire) begin
        clip_cnt <= clip_cnt_next;
        org_cnt  <= org_cnt_next;
        cur_row  <= cur_row_next;
        cur_col  <= cur_col_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result beat; negative cursor coordinates show as zero
  always_ff @(posedge clk) begin
    if (calc_fire) begin
      m_tuser <= status_next;
      m_tdata <= {2'b00,
                  cur_col_next[15] ? 15'd0 : cur_col_next[14:0],
                  cur_row_next[15] ? 15'd0 : cur_row_next[14:0],
                  write_next, skip_next};
    end
  end

endmodule

// ----- hdl/cosc_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cosc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // hold a stalled result beat
  `COSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped")
  `COSC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  // a stack error never reports span counts
  `COSC_ASSERT_SAME(a_err_no_span, m_tvalid && (m_tuser != cosc_pkg::ST_OK), m_tdata[23:0] == 24'd0, "span counts on error")
  // one command at a time: busy right after acceptance
  `COSC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted two beats back to back")
  // reset drops any pending result
  `COSC_ASSERT_NEXT_ALWAYS(a_reset_clear, rst, !m_tvalid, "result valid after reset")

endmodule

bind clip_origin_stack_cursor_engine_unit cosc_checker u_cosc_checker (.*);
